@@ rtl/flr_pkg.sv @@
// Shared types, codes and reset constants of the framed link receiver.
`timescale 1ns / 1ps
`default_nettype none

package flr_pkg;

    localparam int SEQ_BITS         = 3;
    localparam int MAX_FRAME_OCTETS = 256;
    localparam int QUEUE_DEPTH      = 4;
    localparam int SEQ_FIELD_W      = 3;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FLAG_OCTET   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_OCTET = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FLIP_MASK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_PRESET   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NAK_MASK     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_MASK   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RETX_MASK    = 3'd6;

    localparam logic [7:0]  FLAG_OCTET_RST   = 8'h7e;
    localparam logic [7:0]  ESCAPE_OCTET_RST = 8'h7d;
    localparam logic [7:0]  FLIP_MASK_RST    = 8'h20;
    localparam logic [15:0] CRC_PRESET_RST   = 16'hffff;
    localparam logic [7:0]  NAK_MASK_RST     = 8'h80;
    localparam logic [7:0]  RESET_MASK_RST   = 8'h40;
    localparam logic [7:0]  RETX_MASK_RST    = 8'h20;

    localparam logic KIND_OCTET   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        V_DELIVER    = 3'd0,
        V_NAK_SHORT  = 3'd1,
        V_NAK_CRC    = 3'd2,
        V_NAK_ORDER  = 3'd3,
        V_IGNORE_RTX = 3'd4,
        V_RESET_OK   = 3'd5,
        V_NAK_RX     = 3'd6,
        V_OVERRUN    = 3'd7
    } verdict_t;

    typedef enum logic [1:0] {
        REQ_OCTET   = 2'd0,
        REQ_CLOSE   = 2'd1,
        REQ_OVERRUN = 2'd2
    } req_kind_t;

    typedef struct packed {
        logic [7:0]  flag_octet;
        logic [7:0]  escape_octet;
        logic [7:0]  flip_mask;
        logic [15:0] crc_preset;
        logic [7:0]  nak_mask;
        logic [7:0]  reset_mask;
        logic [7:0]  retx_mask;
    } cfg_t;

    typedef struct packed {
        req_kind_t  kind;
        logic [7:0] octet;
        logic [7:0] header;
        logic [7:0] length;
        logic       short_frame;
        logic       crc_ok;
    } req_t;

endpackage

`default_nettype wire

@@ rtl/framed_link_receiver.sv @@
// Top level of the framed link receiver: configuration registers and the front/back pipeline.
//
// Input channel s_*: one raw line octet per request. Flags delimit frames,
// escape octets flip the following octet, the first data octet is the header.
// Result channel m_*: tentative payload octets (m_item_kind 0) as they leave
// the two-octet CRC delay, and one frame verdict (m_item_kind 1) per closing
// flag or overrun abort, with sequence and link state.
// Configuration channel cfg_*: cfg_index selects the register, cfg_data holds
// the value (low 8 bits for octet registers); cfg_ready is always high.
// Throughput: one octet per cycle while the queue has space, set by the CRC
// byte update that the front end computes combinationally. Result path: the
// request for the octet is written into the queue, then taken into the output
// register, where m_valid rises; while that register is held it waits in the queue.
// Stall: while m_ready is low the queue of QUEUE_DEPTH requests absorbs
// results; s_ready drops once it is full and rises when it drains.
// Reset: aresetn low for one cycle restores register defaults, clears the
// framing state, expected sequence and connected flag, and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module framed_link_receiver #(
    parameter int SEQ_BITS         = flr_pkg::SEQ_BITS,
    parameter int MAX_FRAME_OCTETS = flr_pkg::MAX_FRAME_OCTETS,
    parameter int QUEUE_DEPTH      = flr_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [flr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [flr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_line_octet,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_item_kind,
    output logic [7:0]       m_payload_octet,
    output logic [2:0]       m_verdict,
    output logic [flr_pkg::SEQ_FIELD_W-1:0] m_peer_seq,
    output logic [flr_pkg::SEQ_FIELD_W-1:0] m_reply_seq,
    output logic             m_link_connected,
    output logic [7:0]       m_frame_length
);

    flr_pkg::cfg_t cfg_reg, cfg_next;
    flr_pkg::req_t front_req;
    flr_pkg::req_t queue_req;
    logic          front_push;
    logic          queue_valid;
    logic          queue_pop;
    logic          queue_space;

    assign cfg_ready = 1'b1;
    assign s_ready   = queue_space;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                flr_pkg::REG_FLAG_OCTET:   cfg_next.flag_octet   = cfg_data[7:0];
                flr_pkg::REG_ESCAPE_OCTET: cfg_next.escape_octet = cfg_data[7:0];
                flr_pkg::REG_FLIP_MASK:    cfg_next.flip_mask    = cfg_data[7:0];
                flr_pkg::REG_CRC_PRESET:   cfg_next.crc_preset   = cfg_data;
                flr_pkg::REG_NAK_MASK:     cfg_next.nak_mask     = cfg_data[7:0];
                flr_pkg::REG_RESET_MASK:   cfg_next.reset_mask   = cfg_data[7:0];
                flr_pkg::REG_RETX_MASK:    cfg_next.retx_mask    = cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_octet   <= flr_pkg::FLAG_OCTET_RST;
            cfg_reg.escape_octet <= flr_pkg::ESCAPE_OCTET_RST;
            cfg_reg.flip_mask    <= flr_pkg::FLIP_MASK_RST;
            cfg_reg.crc_preset   <= flr_pkg::CRC_PRESET_RST;
            cfg_reg.nak_mask     <= flr_pkg::NAK_MASK_RST;
            cfg_reg.reset_mask   <= flr_pkg::RESET_MASK_RST;
            cfg_reg.retx_mask    <= flr_pkg::RETX_MASK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    flr_front #(
        .MAX_FRAME_OCTETS(MAX_FRAME_OCTETS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .accept  (s_valid && s_ready),
        .octet_in(s_line_octet),
        .push    (front_push),
        .req     (front_req)
    );

    flr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (front_push),
        .push_req (front_req),
        .has_space(queue_space),
        .pop_valid(queue_valid),
        .pop_req  (queue_req),
        .pop      (queue_pop)
    );

    flr_back #(
        .SEQ_BITS(SEQ_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .req_valid       (queue_valid),
        .req             (queue_req),
        .req_pop         (queue_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_payload_octet (m_payload_octet),
        .m_verdict       (m_verdict),
        .m_peer_seq      (m_peer_seq),
        .m_reply_seq     (m_reply_seq),
        .m_link_connected(m_link_connected),
        .m_frame_length  (m_frame_length)
    );

endmodule

`default_nettype wire

@@ rtl/flr_front.sv @@
// Front end: destuffing, framing, CRC delay line and request generation.
`timescale 1ns / 1ps
`default_nettype none

module flr_front #(
    parameter int MAX_FRAME_OCTETS = flr_pkg::MAX_FRAME_OCTETS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire flr_pkg::cfg_t cfg,
    input  wire logic          accept,
    input  wire logic [7:0]    octet_in,
    output logic               push,
    output flr_pkg::req_t      req
);

    localparam int CNT_W = $clog2(MAX_FRAME_OCTETS + 1);

    logic             escaping_reg, escaping_next;
    logic             in_frame_reg, in_frame_next;
    logic [7:0]       header_reg, header_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       delay0_reg, delay0_next;
    logic [7:0]       delay1_reg, delay1_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       octet_x;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [7:0] o;
        o = d ^ crc[7:0];
        o = o ^ {o[3:0], 4'h0};
        return {o, crc[15:8]} ^ {12'h000, o[7:4]} ^ {5'h00, o, 3'b000};
    endfunction

    assign octet_x = escaping_reg ? (octet_in ^ cfg.flip_mask) : octet_in;

    always_comb begin
        escaping_next = escaping_reg;
        in_frame_next = in_frame_reg;
        header_next   = header_reg;
        crc_next      = crc_reg;
        delay0_next   = delay0_reg;
        delay1_next   = delay1_reg;
        count_next    = count_reg;
        push          = 1'b0;
        req.kind        = flr_pkg::REQ_OCTET;
        req.octet       = delay0_reg;
        req.header      = header_reg;
        req.length      = 8'(count_reg - CNT_W'(2));
        req.short_frame = (count_reg < CNT_W'(2));
        req.crc_ok      = ({delay0_reg, delay1_reg} == crc_reg);
        if (accept) begin
            if (octet_in == cfg.flag_octet) begin
                push          = in_frame_reg;
                req.kind      = flr_pkg::REQ_CLOSE;
                crc_next      = cfg.crc_preset;
                escaping_next = 1'b0;
                in_frame_next = 1'b0;
                count_next    = '0;
            end else if (octet_in == cfg.escape_octet) begin
                escaping_next = 1'b1;
            end else begin
                escaping_next = 1'b0;
                if (!in_frame_reg) begin
                    crc_next      = crc_byte(crc_reg, octet_x);
                    header_next   = octet_x;
                    in_frame_next = 1'b1;
                end else if (count_reg == CNT_W'(MAX_FRAME_OCTETS)) begin
                    push          = 1'b1;
                    req.kind      = flr_pkg::REQ_OVERRUN;
                    crc_next      = cfg.crc_preset;
                    in_frame_next = 1'b0;
                    count_next    = '0;
                end else begin
                    if (count_reg >= CNT_W'(2)) begin
                        push     = 1'b1;
                        req.kind = flr_pkg::REQ_OCTET;
                        crc_next = crc_byte(crc_reg, delay0_reg);
                    end
                    delay0_next = delay1_reg;
                    delay1_next = octet_x;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escaping_reg <= 1'b0;
            in_frame_reg <= 1'b0;
            header_reg   <= 8'h00;
            crc_reg      <= flr_pkg::CRC_PRESET_RST;
            count_reg    <= '0;
        end else begin
            escaping_reg <= escaping_next;
            in_frame_reg <= in_frame_next;
            header_reg   <= header_next;
            crc_reg      <= crc_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        delay0_reg <= delay0_next;
        delay1_reg <= delay1_next;
    end

endmodule

`default_nettype wire

@@ rtl/flr_queue.sv @@
// Request queue between the front end and the verdict stage.
`timescale 1ns / 1ps
`default_nettype none

module flr_queue #(
    parameter int DEPTH = flr_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire flr_pkg::req_t push_req,
    output logic               has_space,
    output logic               pop_valid,
    output flr_pkg::req_t      pop_req,
    input  wire logic          pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    flr_pkg::req_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign has_space = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_req   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

@@ rtl/flr_back.sv @@
// Back end: verdict decision, link sequence state and output register.
`timescale 1ns / 1ps
`default_nettype none

module flr_back #(
    parameter int SEQ_BITS = flr_pkg::SEQ_BITS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire flr_pkg::cfg_t cfg,
    input  wire logic          req_valid,
    input  wire flr_pkg::req_t req,
    output logic               req_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_item_kind,
    output logic [7:0]         m_payload_octet,
    output logic [2:0]         m_verdict,
    output logic [flr_pkg::SEQ_FIELD_W-1:0] m_peer_seq,
    output logic [flr_pkg::SEQ_FIELD_W-1:0] m_reply_seq,
    output logic               m_link_connected,
    output logic [7:0]         m_frame_length
);

    localparam int SW = flr_pkg::SEQ_FIELD_W;

    logic [SEQ_BITS-1:0] exp_seq_reg, exp_seq_next;
    logic                conn_reg, conn_next;
    logic                valid_reg, valid_next;
    logic                kind_reg, kind_next;
    logic [7:0]          octet_reg, octet_next;
    flr_pkg::verdict_t   verdict_reg, verdict_next;
    logic [SW-1:0]       peer_reg, peer_next;
    logic [SW-1:0]       reply_reg, reply_next;
    logic                lconn_reg, lconn_next;
    logic [7:0]          len_reg, len_next;
    logic [SEQ_BITS-1:0] seq;

    assign req_pop = req_valid && (!valid_reg || m_ready);
    assign seq     = req.header[SEQ_BITS-1:0];

    always_comb begin
        exp_seq_next = exp_seq_reg;
        conn_next    = conn_reg;
        valid_next   = valid_reg && !m_ready;
        kind_next    = kind_reg;
        octet_next   = octet_reg;
        verdict_next = verdict_reg;
        peer_next    = peer_reg;
        reply_next   = reply_reg;
        lconn_next   = lconn_reg;
        len_next     = len_reg;
        if (req_pop) begin
            valid_next   = 1'b1;
            kind_next    = flr_pkg::KIND_VERDICT;
            octet_next   = 8'h00;
            verdict_next = flr_pkg::V_DELIVER;
            peer_next    = '0;
            len_next     = 8'h00;
            unique case (req.kind)
                flr_pkg::REQ_OCTET: begin
                    kind_next  = flr_pkg::KIND_OCTET;
                    octet_next = req.octet;
                end
                flr_pkg::REQ_OVERRUN: begin
                    verdict_next = flr_pkg::V_OVERRUN;
                end
                flr_pkg::REQ_CLOSE: begin
                    peer_next = SW'(seq);
                    if (req.short_frame) begin
                        verdict_next = flr_pkg::V_NAK_SHORT;
                    end else begin
                        len_next = req.length;
                        if (!req.crc_ok) begin
                            verdict_next = flr_pkg::V_NAK_CRC;
                        end else if ((req.header & cfg.nak_mask) != 8'h00) begin
                            conn_next    = 1'b1;
                            verdict_next = flr_pkg::V_NAK_RX;
                        end else if (seq != exp_seq_reg) begin
                            verdict_next = ((req.header & cfg.retx_mask) != 8'h00)
                                         ? flr_pkg::V_IGNORE_RTX : flr_pkg::V_NAK_ORDER;
                        end else begin
                            exp_seq_next = exp_seq_reg + SEQ_BITS'(1);
                            if ((req.header & cfg.reset_mask) != 8'h00) begin
                                conn_next    = 1'b1;
                                verdict_next = flr_pkg::V_RESET_OK;
                            end
                        end
                    end
                end
                default: begin
                    verdict_next = flr_pkg::V_OVERRUN;
                end
            endcase
            if (req.kind == flr_pkg::REQ_OCTET) begin
                reply_next = '0;
                lconn_next = 1'b0;
            end else begin
                reply_next = SW'(exp_seq_next);
                lconn_next = conn_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_seq_reg <= '0;
            conn_reg    <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            exp_seq_reg <= exp_seq_next;
            conn_reg    <= conn_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        octet_reg   <= octet_next;
        verdict_reg <= verdict_next;
        peer_reg    <= peer_next;
        reply_reg   <= reply_next;
        lconn_reg   <= lconn_next;
        len_reg     <= len_next;
    end

    assign m_valid          = valid_reg;
    assign m_item_kind      = kind_reg;
    assign m_payload_octet  = octet_reg;
    assign m_verdict        = verdict_reg;
    assign m_peer_seq       = peer_reg;
    assign m_reply_seq      = reply_reg;
    assign m_link_connected = lconn_reg;
    assign m_frame_length   = len_reg;

endmodule

`default_nettype wire

@@ rtl/flr_checker.sv @@
// Port-level checker of the framed link receiver and its bind.
`timescale 1ns / 1ps
`default_nettype none

module flr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_item_kind,
    input wire logic [7:0] m_payload_octet,
    input wire logic [2:0] m_verdict,
    input wire logic [flr_pkg::SEQ_FIELD_W-1:0] m_peer_seq,
    input wire logic [flr_pkg::SEQ_FIELD_W-1:0] m_reply_seq,
    input wire logic       m_link_connected,
    input wire logic [7:0] m_frame_length
);

    logic conn_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conn_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && m_item_kind && m_link_connected) begin
            conn_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item_kind)
            && $stable(m_payload_octet) && $stable(m_verdict) && $stable(m_frame_length))
        else $error("result changed while stalled");

    a_octet_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item_kind == flr_pkg::KIND_OCTET) |->
            m_verdict == flr_pkg::V_DELIVER && m_peer_seq == '0 && m_reply_seq == '0
            && !m_link_connected && m_frame_length == 8'h00)
        else $error("payload octet carries verdict fields");

    a_overrun_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item_kind && (m_verdict == flr_pkg::V_OVERRUN) |->
            m_peer_seq == '0 && m_frame_length == 8'h00)
        else $error("overrun verdict with sequence or length");

    a_short_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item_kind && (m_verdict == flr_pkg::V_NAK_SHORT) |->
            m_frame_length == 8'h00)
        else $error("short frame with non-zero length");

    a_conn_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item_kind && conn_seen_reg |-> m_link_connected)
        else $error("link connected flag dropped");

endmodule

bind framed_link_receiver flr_checker u_flr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_item_kind     (m_item_kind),
    .m_payload_octet (m_payload_octet),
    .m_verdict       (m_verdict),
    .m_peer_seq      (m_peer_seq),
    .m_reply_seq     (m_reply_seq),
    .m_link_connected(m_link_connected),
    .m_frame_length  (m_frame_length)
);

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the framed link receiver: stuffed frames in, octets and verdicts out.
`timescale 1ns / 1ps

module testbench;

    localparam int FLAW_NONE    = 0;
    localparam int FLAW_CRC     = 1;
    localparam int FLAW_CUT     = 2;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SEQ_W        = flr_pkg::SEQ_BITS;
    localparam int FIELD_W      = flr_pkg::SEQ_FIELD_W;
    localparam int IDX_W        = flr_pkg::CFG_INDEX_W;

    typedef logic [7:0] octet_q_t [$];

    typedef struct {
        logic                      kind;
        logic [7:0]                octet;
        flr_pkg::verdict_t         verdict;
        logic [FIELD_W-1:0]        peer_seq;
        logic [FIELD_W-1:0]        reply_seq;
        logic                      connected;
        logic [7:0]                length;
    } link_event_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [flr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_line_octet = 8'h00;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_item_kind;
    logic [7:0]             m_payload_octet;
    logic [2:0]             m_verdict;
    logic [FIELD_W-1:0]     m_peer_seq;
    logic [FIELD_W-1:0]     m_reply_seq;
    logic                   m_link_connected;
    logic [7:0]             m_frame_length;

    flr_pkg::cfg_t     link_cfg;
    logic              rx_escaping;
    logic              rx_in_frame;
    logic [7:0]        rx_header;
    logic [15:0]       rx_crc;
    logic [7:0]        rx_delay [2];
    int                rx_count;
    logic [SEQ_W-1:0]  rx_expect_seq;
    logic              rx_connected;

    link_event_t       link_events [$];
    logic [7:0]        line_octets [$];
    int                n_queued = 0;
    int                octets_taken = 0;
    logic [SEQ_W-1:0]  seq_guess = '0;
    logic              calm = 1'b0;
    int                errors = 0;
    int                src_gap = 0;
    int                src_left = 0;
    int                src_pct = 0;
    int                sink_gap = 0;
    int                sink_left = 0;
    int                sink_pct = 0;
    int                stall_cycles = 0;

    framed_link_receiver dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_line_octet     (s_line_octet),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_item_kind      (m_item_kind),
        .m_payload_octet  (m_payload_octet),
        .m_verdict        (m_verdict),
        .m_peer_seq       (m_peer_seq),
        .m_reply_seq      (m_reply_seq),
        .m_link_connected (m_link_connected),
        .m_frame_length   (m_frame_length)
    );

    always #1 aclk = ~aclk;

    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] octet);
        logic [7:0] t;
        t = octet ^ crc[7:0];
        t = t ^ (t << 4);
        return {t, crc[15:8]} ^ {12'h000, t[7:4]} ^ ({8'h00, t} << 3);
    endfunction

    function automatic void restart_rx();
        rx_crc      = link_cfg.crc_preset;
        rx_escaping = 1'b0;
        rx_in_frame = 1'b0;
        rx_count    = 0;
    endfunction

    function automatic void reset_link_model();
        link_cfg.flag_octet   = flr_pkg::FLAG_OCTET_RST;
        link_cfg.escape_octet = flr_pkg::ESCAPE_OCTET_RST;
        link_cfg.flip_mask    = flr_pkg::FLIP_MASK_RST;
        link_cfg.crc_preset   = flr_pkg::CRC_PRESET_RST;
        link_cfg.nak_mask     = flr_pkg::NAK_MASK_RST;
        link_cfg.reset_mask   = flr_pkg::RESET_MASK_RST;
        link_cfg.retx_mask    = flr_pkg::RETX_MASK_RST;
        rx_header     = 8'h00;
        rx_delay[0]   = 8'h00;
        rx_delay[1]   = 8'h00;
        rx_expect_seq = '0;
        rx_connected  = 1'b0;
        restart_rx();
    endfunction

    function automatic void receive_octet(input logic [7:0] raw);
        logic [7:0]  octet;
        link_event_t ev;
        octet        = raw;
        ev.kind      = flr_pkg::KIND_OCTET;
        ev.octet     = 8'h00;
        ev.verdict   = flr_pkg::V_DELIVER;
        ev.peer_seq  = '0;
        ev.reply_seq = '0;
        ev.connected = 1'b0;
        ev.length    = 8'h00;
        if (octet == link_cfg.flag_octet) begin
            if (rx_in_frame) begin
                ev.kind = flr_pkg::KIND_VERDICT;
                if (rx_count < 2) begin
                    ev.verdict = flr_pkg::V_NAK_SHORT;
                end else begin
                    ev.length = 8'(rx_count - 2);
                    if ({rx_delay[0], rx_delay[1]} != rx_crc) begin
                        ev.verdict = flr_pkg::V_NAK_CRC;
                    end else if ((rx_header & link_cfg.nak_mask) != 8'h00) begin
                        rx_connected = 1'b1;
                        ev.verdict = flr_pkg::V_NAK_RX;
                    end else if (rx_header[SEQ_W-1:0] != rx_expect_seq) begin
                        ev.verdict = ((rx_header & link_cfg.retx_mask) != 8'h00) ?
                                     flr_pkg::V_IGNORE_RTX : flr_pkg::V_NAK_ORDER;
                    end else begin
                        rx_expect_seq++;
                        if ((rx_header & link_cfg.reset_mask) != 8'h00) begin
                            rx_connected = 1'b1;
                            ev.verdict = flr_pkg::V_RESET_OK;
                        end
                    end
                end
                ev.peer_seq  = FIELD_W'(rx_header[SEQ_W-1:0]);
                ev.reply_seq = FIELD_W'(rx_expect_seq);
                ev.connected = rx_connected;
                link_events.push_back(ev);
            end
            restart_rx();
            return;
        end
        if (octet == link_cfg.escape_octet) begin
            rx_escaping = 1'b1;
            return;
        end
        if (rx_escaping) begin
            octet = octet ^ link_cfg.flip_mask;
            rx_escaping = 1'b0;
        end
        if (!rx_in_frame) begin
            rx_crc      = crc_ccitt_step(rx_crc, octet);
            rx_header   = octet;
            rx_in_frame = 1'b1;
            return;
        end
        if (rx_count >= flr_pkg::MAX_FRAME_OCTETS) begin
            restart_rx();
            ev.kind      = flr_pkg::KIND_VERDICT;
            ev.verdict   = flr_pkg::V_OVERRUN;
            ev.reply_seq = FIELD_W'(rx_expect_seq);
            ev.connected = rx_connected;
            link_events.push_back(ev);
            return;
        end
        if (rx_count >= 2) begin
            rx_crc   = crc_ccitt_step(rx_crc, rx_delay[0]);
            ev.octet = rx_delay[0];
            link_events.push_back(ev);
        end
        rx_delay[0] = rx_delay[1];
        rx_delay[1] = octet;
        rx_count++;
    endfunction

    function automatic void push_octet(input logic [7:0] octet);
        line_octets.push_back(octet);
        n_queued++;
    endfunction

    function automatic void push_stuffed(input logic [7:0] octet);
        if (octet == link_cfg.flag_octet || octet == link_cfg.escape_octet) begin
            push_octet(link_cfg.escape_octet);
            push_octet(octet ^ link_cfg.flip_mask);
        end else begin
            push_octet(octet);
        end
    endfunction

    function automatic logic [7:0] line_noise();
        logic [7:0] octet;
        case ($urandom_range(0, 7))
            0:       octet = link_cfg.flag_octet;
            1:       octet = link_cfg.escape_octet;
            2:       octet = 8'h00;
            3:       octet = 8'hff;
            default: octet = 8'($urandom);
        endcase
        return octet;
    endfunction

    function automatic void queue_frame(input logic [7:0] hdr, input octet_q_t body,
                                        input int flaw, input logic closed);
        logic [15:0] crc;
        crc = link_cfg.crc_preset;
        push_octet(link_cfg.flag_octet);
        push_stuffed(hdr);
        crc = crc_ccitt_step(crc, hdr);
        foreach (body[i]) begin
            push_stuffed(body[i]);
            crc = crc_ccitt_step(crc, body[i]);
        end
        if (flaw == FLAW_CRC) begin
            crc[$urandom_range(0, 15)] ^= 1'b1;
        end
        if (flaw != FLAW_CUT) begin
            push_stuffed(crc[15:8]);
            push_stuffed(crc[7:0]);
        end
        if (closed) begin
            push_octet(link_cfg.flag_octet);
        end
    endfunction

    function automatic void queue_long_frame(input int n_body);
        octet_q_t   body;
        logic [7:0] hdr;
        hdr = 8'($urandom);
        hdr = hdr & ~(link_cfg.nak_mask | link_cfg.reset_mask | link_cfg.retx_mask);
        hdr[SEQ_W-1:0] = seq_guess;
        repeat (n_body) body.push_back(8'($urandom));
        queue_frame(hdr, body, FLAW_NONE, 1'b1);
        seq_guess++;
    endfunction

    function automatic void queue_line_traffic(input int n_octets);
        int         start;
        int         pick;
        int         flaw;
        int         n_body;
        logic [7:0] hdr;
        octet_q_t   body;
        start = n_queued;
        while (n_queued - start < n_octets) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 5)) push_octet(line_noise());
            end else begin
                pick = $urandom_range(0, 9);
                hdr = 8'($urandom);
                hdr = hdr & ~(link_cfg.nak_mask | link_cfg.reset_mask | link_cfg.retx_mask);
                hdr[SEQ_W-1:0] = seq_guess;
                case (pick)
                    6: hdr = hdr | link_cfg.reset_mask;
                    7: begin
                        hdr = hdr | link_cfg.retx_mask;
                        hdr[SEQ_W-1:0] = SEQ_W'($urandom);
                    end
                    8: hdr = hdr | link_cfg.nak_mask;
                    9: hdr = 8'($urandom);
                    default: ;
                endcase
                n_body = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) :
                                                       $urandom_range(0, 6);
                body.delete();
                repeat (n_body) body.push_back(line_noise());
                case ($urandom_range(0, 11))
                    0:       flaw = FLAW_CRC;
                    1:       flaw = FLAW_CUT;
                    default: flaw = FLAW_NONE;
                endcase
                queue_frame(hdr, body, flaw, 1'b1);
                if (pick <= 6 && flaw == FLAW_NONE) begin
                    seq_guess++;
                end
            end
        end
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] value);
        logic [15:0] data;
        data = value;
        if (idx != flr_pkg::REG_CRC_PRESET) begin
            data[15:8] = 8'($urandom);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            flr_pkg::REG_FLAG_OCTET:   link_cfg.flag_octet   = data[7:0];
            flr_pkg::REG_ESCAPE_OCTET: link_cfg.escape_octet = data[7:0];
            flr_pkg::REG_FLIP_MASK:    link_cfg.flip_mask    = data[7:0];
            flr_pkg::REG_CRC_PRESET:   link_cfg.crc_preset   = data;
            flr_pkg::REG_NAK_MASK:     link_cfg.nak_mask     = data[7:0];
            flr_pkg::REG_RESET_MASK:   link_cfg.reset_mask   = data[7:0];
            flr_pkg::REG_RETX_MASK:    link_cfg.retx_mask    = data[7:0];
            default: ;
        endcase
    endtask

    task automatic program_link(input logic [7:0] flag, input logic [7:0] esc,
                                input logic [7:0] flip, input logic [15:0] preset,
                                input logic [7:0] nak, input logic [7:0] rst,
                                input logic [7:0] retx);
        write_reg(flr_pkg::REG_FLAG_OCTET, {8'h00, flag});
        write_reg(flr_pkg::REG_ESCAPE_OCTET, {8'h00, esc});
        write_reg(flr_pkg::REG_FLIP_MASK, {8'h00, flip});
        write_reg(flr_pkg::REG_CRC_PRESET, preset);
        write_reg(flr_pkg::REG_NAK_MASK, {8'h00, nak});
        write_reg(flr_pkg::REG_RESET_MASK, {8'h00, rst});
        write_reg(flr_pkg::REG_RETX_MASK, {8'h00, retx});
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (octets_taken != n_queued || link_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        seq_guess = rx_expect_seq;
    endtask

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                receive_octet(s_line_octet);
                octets_taken++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (line_octets.size() > 0) begin
                    s_valid      <= 1'b1;
                    s_line_octet <= line_octets.pop_front();
                    src_left--;
                    if (src_left <= 0) begin
                        src_left = $urandom_range(20, 60);
                        src_pct  = $urandom_range(0, 4) * 10;
                    end
                    if (!calm && $urandom_range(0, 99) < src_pct) begin
                        src_gap = $urandom_range(1, 16);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        link_event_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (link_events.size() == 0) begin
                    $display("%0t: result with nothing expected: kind %0h octet %0h verdict %0h",
                             $time, m_item_kind, m_payload_octet, m_verdict);
                    errors++;
                end else begin
                    want = link_events.pop_front();
                    check_field("item_kind", 16'(want.kind), 16'(m_item_kind));
                    check_field("payload_octet", 16'(want.octet), 16'(m_payload_octet));
                    check_field("verdict", 16'(want.verdict), 16'(m_verdict));
                    check_field("peer_seq", 16'(want.peer_seq), 16'(m_peer_seq));
                    check_field("reply_seq", 16'(want.reply_seq), 16'(m_reply_seq));
                    check_field("link_connected", 16'(want.connected),
                                16'(m_link_connected));
                    check_field("frame_length", 16'(want.length), 16'(m_frame_length));
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                sink_left--;
                if (sink_left <= 0) begin
                    sink_left = $urandom_range(20, 60);
                    sink_pct  = $urandom_range(0, 4) * 10;
                end
                if (!calm && $urandom_range(0, 99) < sink_pct) begin
                    sink_gap = $urandom_range(1, 16);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        octet_q_t body;
        reset_link_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        body = '{8'h00, 8'hff, link_cfg.flag_octet};
        queue_frame(8'h00, body, FLAW_NONE, 1'b1);
        body.delete();
        queue_frame(8'h01, body, FLAW_CUT, 1'b1);
        push_octet(link_cfg.escape_octet);
        push_octet(link_cfg.escape_octet);
        push_octet(8'h5e);
        push_octet(8'h01);
        push_octet(link_cfg.flag_octet);
        body = '{8'h11};
        queue_frame(8'h83, body, FLAW_NONE, 1'b1);
        body.delete();
        queue_frame(8'h41, body, FLAW_NONE, 1'b1);
        seq_guess = 2;
        queue_line_traffic(50);
        body = '{8'h42, 8'h99};
        queue_frame({5'h00, seq_guess}, body, FLAW_NONE, 1'b0);
        wait_drained();

        program_link(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)), 16'($urandom),
                     8'h01 << $urandom_range(3, 7), 8'h01 << $urandom_range(3, 7),
                     8'h01 << $urandom_range(3, 7));
        queue_line_traffic(40);
        wait_drained();

        program_link(8'h00, 8'hff, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
        queue_line_traffic(35);
        wait_drained();

        program_link(8'hff, 8'h00, 8'hff, 16'hffff, 8'hff, 8'hff, 8'hff);
        queue_line_traffic(35);
        wait_drained();

        program_link(8'h55, 8'h55, 8'h20, 16'h1d0f, flr_pkg::NAK_MASK_RST,
                     flr_pkg::RESET_MASK_RST, flr_pkg::RETX_MASK_RST);
        queue_line_traffic(35);
        wait_drained();

        program_link(flr_pkg::FLAG_OCTET_RST, flr_pkg::ESCAPE_OCTET_RST,
                     flr_pkg::FLIP_MASK_RST, flr_pkg::CRC_PRESET_RST,
                     flr_pkg::NAK_MASK_RST, flr_pkg::RESET_MASK_RST,
                     flr_pkg::RETX_MASK_RST);
        calm = 1'b1;
        queue_line_traffic(40);
        queue_long_frame(flr_pkg::MAX_FRAME_OCTETS - 1);
        queue_line_traffic(15);
        wait_drained();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/flr_pkg.sv
rtl/flr_front.sv
rtl/flr_queue.sv
rtl/flr_back.sv
rtl/framed_link_receiver.sv
rtl/flr_checker.sv
verif/testbench.sv
